### design/lbc_pkg.sv
package lbc_pkg;

	// Default table depth
	localparam int NUM_BUFFERS_DEF = 16;

	// Field widths fixed by the item format
	localparam int DEV_W    = 8;
	localparam int SECTOR_W = 32;
	localparam int SLOT_W   = 4;
	localparam int TAG_W    = DEV_W + SECTOR_W;

	// Command codes
	typedef enum logic [1:0] {
		CMD_GET       = 2'd0,
		CMD_WRITE     = 2'd1,
		CMD_RELEASE   = 2'd2,
		CMD_DISK_DONE = 2'd3
	} cmd_t;

	// Status codes
	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_BUSY    = 2'd1,
		ST_NOFREE  = 2'd2,
		ST_NOTHELD = 2'd3
	} status_t;

endpackage

### design/lru_block_buffer_cache.sv
// LRU block buffer cache: tag and flag table of NUM_BUFFERS entries with a
// recency order, for a disk buffer layer.
// Command channel: an item (cmd, dev, sector, slot) is taken at a rising edge
// with start high and busy low. Result channel: done is high for exactly one
// cycle with status, granted_slot, need_disk_read and need_disk_write; the
// receiver cannot stall it and must take it in that cycle.
// Handling by command:
//   write, disk done, and any non-get command on a slot that is not held: the
//   result shows in the cycle after the item is taken and busy stays low, so such
//   items may come every cycle.
//   get: scans the tag and rank memories one entry a cycle; the result is
//   registered in S_GEND once the last entry has been checked.
//   release: looks up the entry's rank (the pivot, taken in S_RANK), then sweeps
//   the rank memory one entry a cycle in S_SWEEP; the result follows the last entry.
//   The next item is taken in the cycle the result shows.
// Each memory has a single read port, addressed by the slot when idle and by the sweep counter otherwise.
// Reset: all flags clear, then an init pass over every entry loads the
// initial recency order (busy high) before the first item is taken.
module lru_block_buffer_cache
	import lbc_pkg::*;
#(
	parameter int NUM_BUFFERS = NUM_BUFFERS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [1:0]          cmd,
	input  logic [DEV_W-1:0]    dev,
	input  logic [SECTOR_W-1:0] sector,
	input  logic [SLOT_W-1:0]   slot,
	output logic                done,
	output logic [1:0]          status,
	output logic [SLOT_W-1:0]   granted_slot,
	output logic                need_disk_read,
	output logic                need_disk_write
);

	localparam int IW = $clog2(NUM_BUFFERS);
	localparam logic [IW-1:0] LAST_IDX = IW'(NUM_BUFFERS - 1);

	typedef enum logic [5:0] {
		S_INIT  = 6'b000001,
		S_IDLE  = 6'b000010,
		S_SCAN  = 6'b000100,
		S_GEND  = 6'b001000,
		S_RANK  = 6'b010000,
		S_SWEEP = 6'b100000
	} state_t;

	state_t state_q;

	// Memories: tags and recency ranks
	logic [TAG_W-1:0] tag_mem  [NUM_BUFFERS];
	logic [IW-1:0]    rank_mem [NUM_BUFFERS];

	logic [TAG_W-1:0] tag_rd_s1;
	logic [IW-1:0]    rank_rd_s1;
	logic [IW-1:0]    rd_addr;
	logic             rank_we;
	logic [IW-1:0]    rank_wa;
	logic [IW-1:0]    rank_wd;
	logic             tag_we;

	// Per-entry flags
	logic [NUM_BUFFERS-1:0] assigned_q;
	logic [NUM_BUFFERS-1:0] busy_q;
	logic [NUM_BUFFERS-1:0] valid_q;
	logic [NUM_BUFFERS-1:0] dirty_q;

	// Item registers
	logic [TAG_W-1:0] key_q;
	logic [SLOT_W-1:0] slot_q;
	logic [IW-1:0]    sidx_q;

	// Scan control
	logic [IW-1:0] cnt_q;
	logic          rd_done_q;
	logic          vld_s1;
	logic [IW-1:0] idx_s1;

	logic          hit_q;
	logic [IW-1:0] hit_idx_q;
	logic          vic_q;
	logic [IW-1:0] vic_idx_q;
	logic [IW-1:0] vic_rank_q;
	logic [IW-1:0] pivot_q;

	// Result registers
	logic              done_q;
	logic [1:0]        status_q;
	logic [SLOT_W-1:0] gslot_q;
	logic              nrd_q;
	logic              nwr_q;

	logic          accept;
	logic          slot_ok;
	logic [IW-1:0] slot_idx;
	logic          held;
	logic          match;
	logic          free_ent;
	logic          last_s1;

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;

	// Decode the slot field against the table depth
	assign slot_ok  = (32'(slot) < 32'(NUM_BUFFERS));
	assign slot_idx = IW'(slot);
	assign held     = slot_ok && busy_q[slot_idx];

	// Evaluate the entry whose memory data just arrived
	assign match    = assigned_q[idx_s1] && (tag_rd_s1 == key_q);
	assign free_ent = !busy_q[idx_s1] && !dirty_q[idx_s1];
	assign last_s1  = vld_s1 && (idx_s1 == LAST_IDX);

	// Select the read address: slot lookup when idle, else the sweep counter
	assign rd_addr = (state_q == S_IDLE) ? slot_idx : cnt_q;

	// Rank memory write: init pass and release sweep
	always_comb begin
		rank_we = 1'b0;
		rank_wa = idx_s1;
		rank_wd = rank_rd_s1;
		case (state_q)
			S_INIT: begin
				rank_we = 1'b1;
				rank_wa = cnt_q;
				rank_wd = LAST_IDX - cnt_q;
			end
			S_SWEEP: begin
				rank_we = vld_s1;
				rank_wa = idx_s1;
				if (idx_s1 == sidx_q) begin
					rank_wd = '0;
				end else if (rank_rd_s1 < pivot_q) begin
					rank_wd = rank_rd_s1 + IW'(1);
				end else begin
					rank_wd = rank_rd_s1;
				end
			end
			default: begin
				rank_we = 1'b0;
			end
		endcase
	end

	assign tag_we = (state_q == S_GEND) && !hit_q && vic_q;

	// Memory ports
	always_ff @(posedge clk) begin
		tag_rd_s1  <= tag_mem[rd_addr];
		rank_rd_s1 <= rank_mem[rd_addr];
		if (tag_we) begin
			tag_mem[vic_idx_q] <= key_q;
		end
		if (rank_we) begin
			rank_mem[rank_wa] <= rank_wd;
		end
	end

	// Item payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			key_q  <= {dev, sector};
			slot_q <= slot;
			sidx_q <= slot_idx;
		end
		if (state_q == S_RANK) begin
			pivot_q <= rank_rd_s1;
		end
	end

	// Control, flags and results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_INIT;
			cnt_q      <= '0;
			rd_done_q  <= 1'b0;
			vld_s1     <= 1'b0;
			idx_s1     <= '0;
			hit_q      <= 1'b0;
			hit_idx_q  <= '0;
			vic_q      <= 1'b0;
			vic_idx_q  <= '0;
			vic_rank_q <= '0;
			assigned_q <= '0;
			busy_q     <= '0;
			valid_q    <= '0;
			dirty_q    <= '0;
			done_q     <= 1'b0;
			status_q   <= ST_OK;
			gslot_q    <= '0;
			nrd_q      <= 1'b0;
			nwr_q      <= 1'b0;
		end else begin
			done_q <= 1'b0;
			vld_s1 <= 1'b0;
			case (state_q)
				S_INIT: begin
					// load the initial recency order
					if (cnt_q == LAST_IDX) begin
						cnt_q   <= '0;
						state_q <= S_IDLE;
					end else begin
						cnt_q <= cnt_q + IW'(1);
					end
				end
				S_IDLE: begin
					if (accept) begin
						cnt_q     <= '0;
						rd_done_q <= 1'b0;
						hit_q     <= 1'b0;
						vic_q     <= 1'b0;
						if (cmd == CMD_GET) begin
							state_q <= S_SCAN;
						end else if (!held) begin
							done_q   <= 1'b1;
							status_q <= ST_NOTHELD;
							gslot_q  <= slot;
							nrd_q    <= 1'b0;
							nwr_q    <= 1'b0;
						end else if (cmd == CMD_WRITE) begin
							dirty_q[slot_idx] <= 1'b1;
							done_q   <= 1'b1;
							status_q <= ST_OK;
							gslot_q  <= slot;
							nrd_q    <= 1'b0;
							nwr_q    <= 1'b1;
						end else if (cmd == CMD_DISK_DONE) begin
							valid_q[slot_idx] <= 1'b1;
							dirty_q[slot_idx] <= 1'b0;
							done_q   <= 1'b1;
							status_q <= ST_OK;
							gslot_q  <= slot;
							nrd_q    <= 1'b0;
							nwr_q    <= 1'b0;
						end else begin
							state_q <= S_RANK;
						end
					end
				end
				S_SCAN: begin
					// issue one read a cycle
					if (!rd_done_q) begin
						vld_s1 <= 1'b1;
						idx_s1 <= cnt_q;
						if (cnt_q == LAST_IDX) begin
							rd_done_q <= 1'b1;
						end else begin
							cnt_q <= cnt_q + IW'(1);
						end
					end
					// track first hit and oldest free, clean entry
					if (vld_s1) begin
						if (match && !hit_q) begin
							hit_q     <= 1'b1;
							hit_idx_q <= idx_s1;
						end
						if (free_ent && (!vic_q || rank_rd_s1 > vic_rank_q)) begin
							vic_q      <= 1'b1;
							vic_idx_q  <= idx_s1;
							vic_rank_q <= rank_rd_s1;
						end
					end
					if (last_s1) begin
						state_q <= S_GEND;
					end
				end
				S_GEND: begin
					// grant the hit, recycle the victim or report no buffer
					done_q  <= 1'b1;
					nwr_q   <= 1'b0;
					state_q <= S_IDLE;
					if (hit_q) begin
						gslot_q <= SLOT_W'(hit_idx_q);
						if (busy_q[hit_idx_q]) begin
							status_q <= ST_BUSY;
							nrd_q    <= 1'b0;
						end else begin
							busy_q[hit_idx_q] <= 1'b1;
							status_q <= ST_OK;
							nrd_q    <= !valid_q[hit_idx_q];
						end
					end else if (vic_q) begin
						assigned_q[vic_idx_q] <= 1'b1;
						busy_q[vic_idx_q]     <= 1'b1;
						valid_q[vic_idx_q]    <= 1'b0;
						dirty_q[vic_idx_q]    <= 1'b0;
						status_q <= ST_OK;
						gslot_q  <= SLOT_W'(vic_idx_q);
						nrd_q    <= 1'b1;
					end else begin
						status_q <= ST_NOFREE;
						gslot_q  <= '0;
						nrd_q    <= 1'b0;
					end
				end
				S_RANK: begin
					// pivot rank arrives; start the sweep
					cnt_q     <= '0;
					rd_done_q <= 1'b0;
					state_q   <= S_SWEEP;
				end
				S_SWEEP: begin
					// age entries newer than the pivot, move the slot to front
					if (!rd_done_q) begin
						vld_s1 <= 1'b1;
						idx_s1 <= cnt_q;
						if (cnt_q == LAST_IDX) begin
							rd_done_q <= 1'b1;
						end else begin
							cnt_q <= cnt_q + IW'(1);
						end
					end
					if (last_s1) begin
						busy_q[sidx_q] <= 1'b0;
						done_q   <= 1'b1;
						status_q <= ST_OK;
						gslot_q  <= slot_q;
						nrd_q    <= 1'b0;
						nwr_q    <= 1'b0;
						state_q  <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign done            = done_q;
	assign status          = status_q;
	assign granted_slot    = gslot_q;
	assign need_disk_read  = nrd_q;
	assign need_disk_write = nwr_q;

endmodule

### design/lbc_check.sv
module lbc_check
	import lbc_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input logic [1:0]        cmd,
	input logic              done,
	input logic [1:0]        status,
	input logic [SLOT_W-1:0] granted_slot,
	input logic              need_disk_read,
	input logic              need_disk_write
);

	// A get always occupies the block for its scan
	a_get_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && cmd == CMD_GET) |=> busy)
		else $error("get item did not raise busy");

	// Write and disk done answer in the next cycle
	a_fast_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (cmd == CMD_WRITE || cmd == CMD_DISK_DONE)) |=> done)
		else $error("write or disk done item gave no result");

	// No free buffer reports slot zero with no disk traffic
	a_nofree: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == ST_NOFREE) |->
		(granted_slot == '0 && !need_disk_read && !need_disk_write))
		else $error("no free buffer result malformed");

	// A disk write request only comes with an ok status
	a_wr_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(done && need_disk_write) |-> (status == ST_OK && !need_disk_read))
		else $error("disk write request on a failed command");

	// A busy entry answer asks for no disk traffic
	a_busy_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == ST_BUSY) |-> (!need_disk_read && !need_disk_write))
		else $error("busy answer asked for disk traffic");

endmodule

bind lru_block_buffer_cache lbc_check u_lbc_check (.*);

### tb/lbc_checker.sv
module lbc_checker
	import lbc_pkg::*;
#(
	parameter int NUM_BUFFERS = NUM_BUFFERS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic                busy,
	input  logic [1:0]          cmd,
	input  logic [DEV_W-1:0]    dev,
	input  logic [SECTOR_W-1:0] sector,
	input  logic [SLOT_W-1:0]   slot,
	input  logic                done,
	input  logic [1:0]          status,
	input  logic [SLOT_W-1:0]   granted_slot,
	input  logic                need_disk_read,
	input  logic                need_disk_write,
	output int                  mismatch_cnt,
	output int                  open_cnt
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		status_t           st;
		logic [SLOT_W-1:0] slot_id;
		logic              rd;
		logic              wr;
	} blk_result_t;

	// Shadow of the buffer table
	logic [DEV_W-1:0]    tag_dev [NUM_BUFFERS];
	logic [SECTOR_W-1:0] tag_sec [NUM_BUFFERS];
	bit                  tag_set [NUM_BUFFERS];
	bit                  held    [NUM_BUFFERS];
	bit                  loaded  [NUM_BUFFERS];
	bit                  dirty   [NUM_BUFFERS];
	int                  age_rank[NUM_BUFFERS];

	blk_result_t pending_results[$];

	// Return the table to its post-reset contents
	function automatic void clear_table();
		int i;
		for (i = 0; i < NUM_BUFFERS; i++) begin
			tag_dev[i]  = '0;
			tag_sec[i]  = '0;
			tag_set[i]  = 1'b0;
			held[i]     = 1'b0;
			loaded[i]   = 1'b0;
			dirty[i]    = 1'b0;
			age_rank[i] = NUM_BUFFERS - 1 - i;
		end
	endfunction

	// Apply one item to the shadow table and return the result it causes
	function automatic blk_result_t buffer_lookup(cmd_t op, logic [DEV_W-1:0] d,
			logic [SECTOR_W-1:0] s, logic [SLOT_W-1:0] sl);
		blk_result_t res;
		int i;
		int hit_idx;
		int victim;
		int old_rank;
		res = '{st: ST_OK, slot_id: sl, rd: 1'b0, wr: 1'b0};
		if (op == CMD_GET) begin
			hit_idx = -1;
			for (i = 0; i < NUM_BUFFERS; i++)
				if (hit_idx < 0 && tag_set[i] && tag_dev[i] == d && tag_sec[i] == s)
					hit_idx = i;
			if (hit_idx >= 0) begin
				res.slot_id = hit_idx[SLOT_W-1:0];
				if (held[hit_idx]) begin
					res.st = ST_BUSY;
				end else begin
					held[hit_idx] = 1'b1;
					res.rd = !loaded[hit_idx];
				end
				return res;
			end
			// Recycle the oldest entry that is free and clean
			victim = -1;
			for (i = 0; i < NUM_BUFFERS; i++)
				if (!held[i] && !dirty[i] && (victim < 0 || age_rank[i] > age_rank[victim]))
					victim = i;
			if (victim < 0) begin
				res.st = ST_NOFREE;
				res.slot_id = '0;
				return res;
			end
			tag_dev[victim] = d;
			tag_sec[victim] = s;
			tag_set[victim] = 1'b1;
			held[victim]    = 1'b1;
			loaded[victim]  = 1'b0;
			dirty[victim]   = 1'b0;
			res.slot_id = victim[SLOT_W-1:0];
			res.rd = 1'b1;
			return res;
		end
		if (int'(sl) >= NUM_BUFFERS || !held[sl]) begin
			res.st = ST_NOTHELD;
			return res;
		end
		case (op)
			CMD_WRITE: begin
				dirty[sl] = 1'b1;
				res.wr = 1'b1;
			end
			CMD_RELEASE: begin
				old_rank = age_rank[sl];
				for (i = 0; i < NUM_BUFFERS; i++)
					if (age_rank[i] < old_rank)
						age_rank[i]++;
				age_rank[sl] = 0;
				held[sl] = 1'b0;
			end
			default: begin
				loaded[sl] = 1'b1;
				dirty[sl]  = 1'b0;
			end
		endcase
		return res;
	endfunction

	task automatic flag_error(string msg);
		mismatch_cnt++;
		if (mismatch_cnt <= 10)
			$display("%0t: %s", $time, msg);
	endtask

	// Check results against the oldest expectation, then queue the new item's
	always @(posedge clk or negedge arst_n) begin : watch
		blk_result_t want;
		if (!arst_n) begin
			clear_table();
			pending_results.delete();
			mismatch_cnt = 0;
		end else begin
			if (done) begin
				if (pending_results.size() == 0) begin
					flag_error($sformatf("result with nothing expected: status %0d slot %0d",
						status, granted_slot));
				end else begin
					want = pending_results.pop_front();
					if (status !== want.st || granted_slot !== want.slot_id ||
							need_disk_read !== want.rd || need_disk_write !== want.wr)
						flag_error($sformatf({"result mismatch: status %0d/%0d slot %0d/%0d",
							" rd %0b/%0b wr %0b/%0b (expected/actual)"},
							want.st, status, want.slot_id, granted_slot,
							want.rd, need_disk_read, want.wr, need_disk_write));
				end
			end
			if (start && !busy)
				pending_results.push_back(buffer_lookup(cmd_t'(cmd), dev, sector, slot));
		end
		open_cnt = pending_results.size();
	end

endmodule

### tb/tb_top.sv
module tb_top;
	import lbc_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NB          = NUM_BUFFERS_DEF;
	localparam int ITEM_TARGET = 1800;
	localparam int IDLE_LIMIT  = 2000;
	localparam int POOL_SIZE   = 24;

	logic                clk    = 1'b0;
	logic                arst_n = 1'b0;
	logic                start  = 1'b0;
	logic [1:0]          cmd    = CMD_GET;
	logic [DEV_W-1:0]    dev    = '0;
	logic [SECTOR_W-1:0] sector = '0;
	logic [SLOT_W-1:0]   slot   = '0;
	logic                busy;
	logic                done;
	logic [1:0]          status;
	logic [SLOT_W-1:0]   granted_slot;
	logic                need_disk_read;
	logic                need_disk_write;

	int mismatch_cnt;
	int open_cnt;

	// Handshake bookkeeping for the stimulus side
	int                taken_cnt    = 0;
	int                back_cnt     = 0;
	int                quiet_cycles = 0;
	status_t           last_st      = ST_OK;
	logic [SLOT_W-1:0] last_slot    = '0;

	int                burst_left = 0;
	logic [DEV_W-1:0]    pool_dev[POOL_SIZE];
	logic [SECTOR_W-1:0] pool_sec[POOL_SIZE];
	logic [SLOT_W-1:0]   held_pool[$];

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	lru_block_buffer_cache #(.NUM_BUFFERS(NB)) DUT (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.cmd             (cmd),
		.dev             (dev),
		.sector          (sector),
		.slot            (slot),
		.done            (done),
		.status          (status),
		.granted_slot    (granted_slot),
		.need_disk_read  (need_disk_read),
		.need_disk_write (need_disk_write)
	);

	lbc_checker #(.NUM_BUFFERS(NB)) u_chk (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.cmd             (cmd),
		.dev             (dev),
		.sector          (sector),
		.slot            (slot),
		.done            (done),
		.status          (status),
		.granted_slot    (granted_slot),
		.need_disk_read  (need_disk_read),
		.need_disk_write (need_disk_write),
		.mismatch_cnt    (mismatch_cnt),
		.open_cnt        (open_cnt)
	);

	// Count handshakes, latch the latest result, and watch for a stall
	always @(posedge clk) begin
		if (start && !busy)
			taken_cnt <= taken_cnt + 1;
		if (done) begin
			back_cnt  <= back_cnt + 1;
			last_st   <= status_t'(status);
			last_slot <= granted_slot;
		end
		if ((start && !busy) || done)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == IDLE_LIMIT) begin
			$display("tb_top: done, errors");
			$finish;
		end
	end

	// Mostly short gaps, a few long ones, and zero-gap bursts now and then
	function automatic int next_gap();
		int r;
		if (burst_left > 0) begin
			burst_left--;
			return 0;
		end
		r = $urandom_range(99);
		if (r < 4) begin
			burst_left = $urandom_range(40, 20);
			return 0;
		end
		if (r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(3, 1);
		if (r < 97)
			return $urandom_range(10, 4);
		return $urandom_range(60, 20);
	endfunction

	// Present one item and hold it until it is taken; start is left high
	task automatic send_item(cmd_t op, logic [DEV_W-1:0] d, logic [SECTOR_W-1:0] s,
			logic [SLOT_W-1:0] sl);
		int gap;
		gap = next_gap();
		if (gap > 0) begin
			if (start)
				start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start  <= 1'b1;
		cmd    <= op;
		dev    <= d;
		sector <= s;
		slot   <= sl;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	// Drop start and hold until every item has its result
	task automatic drain();
		if (start)
			start <= 1'b0;
		do
			@(posedge clk);
		while (taken_cnt != back_cnt);
	endtask

	task automatic get_block(logic [DEV_W-1:0] d, logic [SECTOR_W-1:0] s,
			output status_t st, output logic [SLOT_W-1:0] sl);
		send_item(CMD_GET, d, s, '0);
		drain();
		st = last_st;
		sl = last_slot;
	endtask

	// Mostly reuse known blocks so that hits and busy entries occur
	task automatic pick_block(output logic [DEV_W-1:0] d, output logic [SECTOR_W-1:0] s);
		int k;
		if ($urandom_range(99) < 80) begin
			k = $urandom_range(POOL_SIZE - 1);
			d = pool_dev[k];
			s = pool_sec[k];
		end else begin
			d = DEV_W'($urandom_range(255));
			s = $urandom;
		end
	endtask

	// Get a block, work on it, and usually give it back
	task automatic block_session();
		status_t           st;
		logic [SLOT_W-1:0] sl;
		logic [DEV_W-1:0]    d;
		logic [SECTOR_W-1:0] s;
		pick_block(d, s);
		get_block(d, s, st, sl);
		if (st != ST_OK)
			return;
		if ($urandom_range(99) < 10)
			send_item(CMD_GET, d, s, '0);
		if ($urandom_range(99) < 50)
			send_item(CMD_WRITE, DEV_W'($urandom_range(255)), $urandom, sl);
		if ($urandom_range(99) < 60)
			send_item(CMD_DISK_DONE, DEV_W'($urandom_range(255)), $urandom, sl);
		if ($urandom_range(99) < 85)
			send_item(CMD_RELEASE, DEV_W'($urandom_range(255)), $urandom, sl);
		else
			held_pool.push_back(sl);
	endtask

	initial begin : stim
		status_t             st;
		logic [SLOT_W-1:0]   sl;
		logic [SLOT_W-1:0]   first_sl;
		logic [DEV_W-1:0]    d;
		logic [SECTOR_W-1:0] s;
		int                  r;
		int                  k;

		for (k = 0; k < POOL_SIZE; k++) begin
			pool_dev[k] = DEV_W'($urandom_range(3));
			pool_sec[k] = $urandom;
		end
		pool_dev[0] = '0;
		pool_sec[0] = '0;
		pool_dev[1] = '1;
		pool_sec[1] = '1;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Miss on an empty table, busy hit, write, disk done, release
		get_block('0, '0, st, first_sl);
		send_item(CMD_GET, '0, '0, '0);
		send_item(CMD_WRITE, '1, '1, first_sl);
		send_item(CMD_DISK_DONE, '0, '0, first_sl);
		send_item(CMD_RELEASE, '0, '0, first_sl);
		drain();
		// Hit on a free entry that already holds data, then give it back
		get_block('0, '0, st, sl);
		send_item(CMD_RELEASE, '0, '0, sl);
		// Commands on an entry nobody holds
		send_item(CMD_WRITE, '0, '0, first_sl);
		send_item(CMD_RELEASE, '0, '0, first_sl);
		send_item(CMD_DISK_DONE, '0, '0, '0);
		drain();
		// Hold every entry, then ask once more with nothing left to recycle
		for (k = 0; k < NB; k++) begin
			d = (k == 0) ? '1 : DEV_W'(k);
			s = (k == 0) ? '1 : $urandom;
			get_block(d, s, st, sl);
			if (st == ST_OK)
				held_pool.push_back(sl);
		end
		get_block(8'h80, 32'h8000_0000, st, sl);

		// Random traffic: mostly whole sessions, some leftovers released, some noise
		while (taken_cnt < ITEM_TARGET) begin
			r = $urandom_range(99);
			if (held_pool.size() > 0 && (r < 12 || held_pool.size() > 12)) begin
				k = $urandom_range(held_pool.size() - 1);
				sl = held_pool[k];
				held_pool.delete(k);
				if ($urandom_range(1))
					send_item(CMD_DISK_DONE, DEV_W'($urandom_range(255)), $urandom, sl);
				send_item(CMD_RELEASE, DEV_W'($urandom_range(255)), $urandom, sl);
			end else if (r < 75) begin
				block_session();
			end else begin
				repeat ($urandom_range(6, 1)) begin
					pick_block(d, s);
					send_item(cmd_t'($urandom_range(3)), d, s, SLOT_W'($urandom_range(15)));
				end
			end
		end

		drain();
		repeat (NB + 8) @(posedge clk);
		if (mismatch_cnt == 0 && open_cnt == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

endmodule
